// File: rtl/mexp_pkg.sv
// Shared types, constants and the sequencer microprogram for the modular
// exponentiation unit. No dependencies; used by mexp_mulmod and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int unsigned ResW = 30;
  localparam int unsigned ExpW = 63;
  localparam int unsigned PcW  = 4;

  // Prime modulus, its double, the inverse exponent and the Barrett factor
  // floor(2^60 / P_MOD).
  localparam logic [ResW-1:0] P_MOD   = 30'd1000000007;
  localparam logic [31:0]     TWO_P   = 32'd2000000014;
  localparam logic [ExpW-1:0] INV_EXP = 63'd1000000005;
  localparam logic [30:0]     MU      = 31'd1152921496;

  // Program addresses
  localparam logic [PcW-1:0] ST_INIT   = 4'd0;
  localparam logic [PcW-1:0] ST_AMUL   = 4'd1;
  localparam logic [PcW-1:0] ST_AQUOT  = 4'd2;
  localparam logic [PcW-1:0] ST_AREM   = 4'd3;
  localparam logic [PcW-1:0] ST_ARED   = 4'd4;
  localparam logic [PcW-1:0] ST_SMUL   = 4'd5;
  localparam logic [PcW-1:0] ST_SQUOT  = 4'd6;
  localparam logic [PcW-1:0] ST_SREM   = 4'd7;
  localparam logic [PcW-1:0] ST_SRED   = 4'd8;
  localparam logic [PcW-1:0] ST_DONE   = 4'd9;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_ACC_SQ,
    MS_SQ_SQ,
    MS_QUOT,
    MS_REM
  } mul_sel_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_ACC,
    WB_SQ
  } wb_sel_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_EXP_ZERO,
    C_BIT_CLEAR,
    C_EXP_HI_ZERO
  } cond_e;

  typedef struct packed {
    mul_sel_e       mul;
    wb_sel_e        wb;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           shift;
    logic           done;
  } ucode_t;

  function automatic ucode_t mexp_ucode(input logic [PcW-1:0] pc);
    ucode_t uw;
    uw = '{mul: MS_NONE, wb: WB_NONE, cond: C_NEXT, target: ST_INIT,
           shift: 1'b0, done: 1'b0};
    unique case (pc)
      ST_INIT: begin
        uw.cond   = C_EXP_ZERO;
        uw.target = ST_DONE;
      end
      ST_AMUL: begin
        uw.mul    = MS_ACC_SQ;
        uw.cond   = C_BIT_CLEAR;
        uw.target = ST_SMUL;
      end
      ST_AQUOT: uw.mul = MS_QUOT;
      ST_AREM:  uw.mul = MS_REM;
      ST_ARED:  uw.wb  = WB_ACC;
      ST_SMUL: begin
        uw.mul    = MS_SQ_SQ;
        uw.cond   = C_EXP_HI_ZERO;
        uw.target = ST_DONE;
      end
      ST_SQUOT: uw.mul = MS_QUOT;
      ST_SREM:  uw.mul = MS_REM;
      ST_SRED: begin
        uw.wb     = WB_SQ;
        uw.shift  = 1'b1;
        uw.cond   = C_ALWAYS;
        uw.target = ST_AMUL;
      end
      default: uw.done = 1'b1;
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mexp_mulmod.sv
// Shared modular multiplier: one 31x31 multiplier reused for the product and
// both Barrett reduction products, plus the final correction. Uses mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
  input  wire logic                clk_i,
  input  wire mexp_pkg::mul_sel_e  sel_i,
  input  wire logic [29:0]         acc_i,
  input  wire logic [29:0]         sq_i,
  output logic [29:0]              red_o
);
  import mexp_pkg::*;

  logic [30:0] op_a, op_b;
  logic [61:0] mul_w;
  logic [61:0] prod_q;
  logic [31:0] plo_q;
  logic [31:0] rem_w;

  always_comb begin
    unique case (sel_i)
      MS_ACC_SQ: begin
        op_a = {1'b0, acc_i};
        op_b = {1'b0, sq_i};
      end
      MS_SQ_SQ: begin
        op_a = {1'b0, sq_i};
        op_b = {1'b0, sq_i};
      end
      // q1 = P >> 29, times floor(2^60 / p)
      MS_QUOT: begin
        op_a = prod_q[59:29];
        op_b = MU;
      end
      // q3 = (q1 * mu) >> 31, times p
      MS_REM: begin
        op_a = prod_q[61:31];
        op_b = {1'b0, P_MOD};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_w = 62'(op_a) * 62'(op_b);

  always_ff @(posedge clk_i) begin
    if (sel_i != MS_NONE) begin
      prod_q <= mul_w;
    end
    // keep low word of the full product for the remainder
    if (sel_i == MS_QUOT) begin
      plo_q <= prod_q[31:0];
    end
  end

  // Remainder lies in [0, 3p); fold it down with a single subtraction of 2p or p.
  assign rem_w = plo_q - prod_q[31:0];

  always_comb begin
    priority if (rem_w >= TWO_P) begin
      red_o = 30'(rem_w - TWO_P);
    end else if (rem_w >= {2'b00, P_MOD}) begin
      red_o = 30'(rem_w - {2'b00, P_MOD});
    end else begin
      red_o = rem_w[29:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_unit.sv
// Sequencing: a zero base or a zero exponent goes straight from the accepted beat to the
// result; otherwise the loop runs a multiply for each set exponent bit and a square for
// each bit below the top set bit. The one shared multiplier sets the run time: each
// multiply and each square uses it for three steps plus a fold; the top bit skips its square.
// Throughput: one item at a time; the next beat is taken as soon as the result
// moves to the output register. Reset clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [29:0] base_i,
  input  wire logic [62:0] exponent_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [29:0]      residue_o
);
  import mexp_pkg::*;

  logic                busy_q, busy_d;
  logic [PcW-1:0]      pc_q, pc_d;
  logic [ResW-1:0]     acc_q, acc_d;
  logic [ResW-1:0]     sq_q, sq_d;
  logic [ExpW-1:0]     exp_q, exp_d;
  logic                out_valid_q, out_valid_d;
  logic [ResW-1:0]     residue_q, residue_d;
  ucode_t              uw;
  mul_sel_e            mul_sel;
  logic                taken;
  logic [ResW-1:0]     red;
  logic                in_fire;

  assign in_ready_o  = ~busy_q;
  assign in_fire     = in_valid_i & ~busy_q;
  assign out_valid_o = out_valid_q;
  assign residue_o   = residue_q;

  assign uw      = mexp_ucode(pc_q);
  assign mul_sel = busy_q ? uw.mul : MS_NONE;

  mexp_mulmod u_mulmod (
    .clk_i (clk_i),
    .sel_i (mul_sel),
    .acc_i (acc_q),
    .sq_i  (sq_q),
    .red_o (red)
  );

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:      taken = 1'b1;
      C_EXP_ZERO:    taken = (exp_q == '0);
      C_BIT_CLEAR:   taken = ~exp_q[0];
      C_EXP_HI_ZERO: taken = (exp_q[ExpW-1:1] == '0);
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    exp_d       = exp_q;
    residue_d   = residue_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (in_fire) begin
      busy_d = 1'b1;
      pc_d   = ST_INIT;
      sq_d   = (base_i >= P_MOD) ? base_i - P_MOD : base_i;
      // zero base: force the result to 0 and skip the loop
      if (base_i == '0) begin
        acc_d = '0;
        exp_d = '0;
      end else begin
        acc_d = ResW'(1);
        exp_d = func_i ? INV_EXP : exponent_i;
      end
    end else if (busy_q) begin
      if (uw.done) begin
        // hold at the end until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          residue_d   = acc_q;
          busy_d      = 1'b0;
        end
      end else begin
        pc_d = taken ? uw.target : pc_q + PcW'(1);
        unique case (uw.wb)
          WB_ACC:  acc_d = red;
          WB_SQ:   sq_d  = red;
          default: ;
        endcase
        if (uw.shift) begin
          exp_d = exp_q >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    sq_q      <= sq_d;
    exp_q     <= exp_d;
    residue_q <= residue_d;
  end

endmodule

`default_nettype wire
